@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros: concurrent assertion macros
// ASSERT_IMPLY checks that cond implies prop. ASSERT_NEVER checks that cond never holds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/kes_pkg.sv @@
// ---------------------------------------------------------------------------
// kes_pkg: shared types and constants of the Kepler equation solver
// Holds the fixed-point constants, the CORDIC arctangent table, the gain
// correction, the command struct from the controller to the datapath
// and the status struct into the controller.
// ---------------------------------------------------------------------------
`default_nettype none
package kes_pkg;
	localparam int FRAC_BITS = 28;
	localparam int AW        = 31;   // angle field width
	localparam int EW        = 28;   // eccentricity width
	localparam int TOLW      = 16;
	localparam int LIMW      = 7;
	localparam int IW        = 34;   // signed internal width
	localparam int DW        = 30;   // divisor width
	localparam int QW        = 2 * FRAC_BITS + 4;
	localparam int CW        = 6;    // step counter width
	localparam int XW        = 5;    // CORDIC index width
	localparam int GW        = 29;   // gain correction width
	localparam int MAX_STEPS = 64;

	localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;
	localparam logic [AW-1:0] PI_Q = AW'((PI_Q60 + (64'd1 << (59 - FRAC_BITS)))
		>> (60 - FRAC_BITS));
	localparam logic [AW-1:0] TWO_PI_Q = AW'((PI_Q60 + (64'd1 << (58 - FRAC_BITS)))
		>> (59 - FRAC_BITS));
	localparam logic [AW-1:0] HALF_PI_Q = AW'((PI_Q60 + (64'd1 << (60 - FRAC_BITS)))
		>> (61 - FRAC_BITS));
	localparam logic [32:0] QCAP = 33'd1 << (FRAC_BITS + 4);

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_LIM = 2'd1;
	localparam logic [1:0] REG_THR = 2'd2;

	typedef logic signed [IW-1:0] atan_tab_t [0:FRAC_BITS];

	typedef struct packed {
		logic            load;
		logic            mul;
		logic            cinit;
		logic            cstep;
		logic            prep;
		logic            dstep;
		logic            upd;
		logic [XW-1:0]   cidx;
	} kes_cmd_t;

	typedef struct packed {
		logic conv;
		logic out_free;
	} kes_stat_t;

	// shift-subtract quotient, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			q = q << 1;
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t t;
		logic [63:0] v;
		logic [63:0] term;
		int e;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			if (i == 0) begin
				v = PI_Q60;
			end else begin
				v = '0;
				for (int k = 0; k < 32; k++) begin
					e = 62 - i * (2 * k + 1);
					if (e >= 0) begin
						term = udiv64(64'd1 << e, 64'(2 * k + 1));
						if (k % 2 == 1) v = v - term;
						else v = v + term;
					end
				end
			end
			t[i] = IW'((v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
		end
		return t;
	endfunction

	function automatic logic [GW-1:0] build_gain();
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		logic [63:0] g;
		x = 64'sd1 << FRAC_BITS;
		y = '0;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
			end else begin
				x = x - ys;
				y = y + xs;
			end
		end
		g = udiv64(64'd1 << (2 * FRAC_BITS), x);
		return GW'(g);
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();
	localparam logic [GW-1:0] GAIN_COMP = build_gain();
endpackage
`default_nettype wire

@@ rtl/core/kepler_equation_solver.sv @@
// ---------------------------------------------------------------------------
// kepler_equation_solver: Newton-Raphson solver for E - e*sin(E) = M
// Unsigned Q3.28 angles, Q0.28 eccentricity; CORDIC sine and cosine,
// bit-serial step division, iterate saturated to [0, two pi].
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    mean_anomaly, eccentricity
// out      source     out_valid / out_ready  eccentric_anomaly, status, iterations_used
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request runs Newton steps up to the iteration limit; in each step
// 29 CORDIC micro-rotations and 60 divider bit steps dominate the work;
// ready returns when the result is stored in the output register.
// One request is in flight at a time; the next is taken once the result
// sits in the output register. Configuration is always ready.
// Reset: tolerance 1, limit 32, threshold 0.8 in Q0.28.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module kepler_equation_solver
	import kes_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [AW-1:0] mean_anomaly,
	input  wire logic [EW-1:0] eccentricity,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [AW-1:0]      eccentric_anomaly,
	output logic               status,
	output logic [LIMW-1:0]    iterations_used,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [EW-1:0] cfg_data
);
	logic [TOLW-1:0] tol_q;
	logic [LIMW-1:0] lim_q;
	logic [EW-1:0]   thr_q;
	kes_cmd_t        cmd;
	kes_stat_t       stat;
	logic            emit, conv;
	logic [AW-1:0]   ang;
	logic [LIMW-1:0] iters;
	logic            ov_q;
	logic [AW-1:0]   ecc_q;
	logic            st_q;
	logic [LIMW-1:0] it_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOLW'(1);
			lim_q <= LIMW'(32);
			thr_q <= EW'(214748365);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOL: tol_q <= cfg_data[TOLW-1:0];
				REG_LIM: lim_q <= cfg_data[LIMW-1:0];
				REG_THR: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stat.conv     = conv;
	assign stat.out_free = !ov_q || out_ready;

	kes_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.iteration_limit (lim_q),
		.stat            (stat),
		.cmd             (cmd),
		.emit            (emit),
		.iters           (iters)
	);

	kes_dp u_dp (
		.clk                (clk),
		.cmd                (cmd),
		.mean_anomaly       (mean_anomaly),
		.eccentricity       (eccentricity),
		.high_ecc_threshold (thr_q),
		.step_tolerance     (tol_q),
		.ang                (ang),
		.conv               (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ecc_q <= ang;
			st_q  <= !conv;
			it_q  <= iters;
		end
	end

	assign out_valid         = ov_q;
	assign eccentric_anomaly = ecc_q;
	assign status            = st_q;
	assign iterations_used   = it_q;

	`ASSERT_IMPLY(a_ecc_range, clk, arst_n, out_valid, eccentric_anomaly <= TWO_PI_Q)
	`ASSERT_IMPLY(a_iter_range, clk, arst_n, out_valid,
		iterations_used != '0 && iterations_used <= LIMW'(MAX_STEPS))
	`ASSERT_NEVER(a_emit_busy, clk, arst_n, emit && ov_q && !out_ready)
	`ASSERT_IMPLY(a_conv_early, clk, arst_n, out_valid && !status,
		iterations_used <= lim_q || lim_q == '0 || lim_q > LIMW'(MAX_STEPS))
endmodule
`default_nettype wire

@@ rtl/core/kes_ctrl.sv @@
// ---------------------------------------------------------------------------
// kes_ctrl: solver sequencer
// Steps each request through gain scaling, the CORDIC rotation, the step
// division and the iterate update, and counts Newton steps to the limit.
// ---------------------------------------------------------------------------
`default_nettype none
module kes_ctrl
	import kes_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [LIMW-1:0] iteration_limit,
	input  wire kes_stat_t       stat,
	output kes_cmd_t             cmd,
	output logic                 emit,
	output logic [LIMW-1:0]      iters
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_CINIT = 3'd2;
	localparam logic [2:0] S_CORD  = 3'd3;
	localparam logic [2:0] S_PREP  = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_UPD   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;
	localparam logic [CW-1:0] CORD_LAST = CW'(FRAC_BITS);
	localparam logic [CW-1:0] DIV_LAST  = CW'(QW - 1);

	logic [2:0]      state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [LIMW-1:0] iter_q, iter_d;
	logic [LIMW-1:0] lim;
	logic            chk_q, chk_d;

	always_comb begin
		if (iteration_limit == '0) lim = LIMW'(1);
		else if (iteration_limit > LIMW'(MAX_STEPS)) lim = LIMW'(MAX_STEPS);
		else lim = iteration_limit;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		iter_d   = iter_q;
		chk_d    = 1'b0;
		cmd      = '0;
		cmd.cidx = cnt_q[XW-1:0];
		emit     = 1'b0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					iter_d   = '0;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CINIT;
			end
			S_CINIT: begin
				// after an update, decide first whether to stop
				if (chk_q && (stat.conv || iter_q == lim)) begin
					state_d = S_FIN;
				end else begin
					cmd.cinit = 1'b1;
					cnt_d     = '0;
					state_d   = S_CORD;
				end
			end
			S_CORD: begin
				cmd.cstep = 1'b1;
				if (cnt_q == CORD_LAST) begin
					state_d = S_PREP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.dstep = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_UPD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				iter_d  = iter_q + 1'b1;
				chk_d   = 1'b1;
				state_d = S_CINIT;
			end
			S_FIN: begin
				// hold until the output register is free
				if (stat.out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			iter_q  <= '0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			iter_q  <= iter_d;
			chk_q   <= chk_d;
		end
	end

	assign iters = iter_q;
endmodule
`default_nettype wire

@@ rtl/core/kes_dp.sv @@
// ---------------------------------------------------------------------------
// kes_dp: solver datapath
// Iterate register, rotation-mode CORDIC (one micro-rotation a cycle),
// restoring divider (one quotient bit a cycle) and the saturating update.
// ---------------------------------------------------------------------------
`default_nettype none
module kes_dp
	import kes_pkg::*;
(
	input  wire logic            clk,
	input  wire kes_cmd_t        cmd,
	input  wire logic [AW-1:0]   mean_anomaly,
	input  wire logic [EW-1:0]   eccentricity,
	input  wire logic [EW-1:0]   high_ecc_threshold,
	input  wire logic [TOLW-1:0] step_tolerance,
	output logic [AW-1:0]        ang,
	output logic                 conv
);
	logic [AW-1:0]          m_q, ang_q;
	logic [EW-1:0]          e_q, mag_q;
	logic signed [IW-1:0]   x_q, y_q, z_q;
	logic                   neg_q, fneg_q, conv_q;
	logic [QW-1:0]          a_sh_q, quo_q;
	logic [DW-1:0]          d_q, rem_q;

	logic [AW-1:0]          m_min;
	logic [EW+GW-1:0]       prod;
	logic signed [IW-1:0]   z0, z1, xs, ys, ec, es, f, fp;
	logic                   neg1;
	logic [31:0]            af;
	logic [DW:0]            rem_n;
	logic                   ge;
	logic [32:0]            qs;
	logic signed [35:0]     stp, nxt, dif;
	logic [AW-1:0]          nxt_c;

	assign m_min = (mean_anomaly > TWO_PI_Q) ? TWO_PI_Q : mean_anomaly;
	assign prod  = e_q * GAIN_COMP;

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		z0 = IW'(ang_q);
		if (ang_q > PI_Q) z0 = IW'(ang_q) - IW'(TWO_PI_Q);
		z1   = z0;
		neg1 = 1'b0;
		if (z0 > $signed(IW'(HALF_PI_Q))) begin
			z1   = z0 - IW'(PI_Q);
			neg1 = 1'b1;
		end else if (z0 < -$signed(IW'(HALF_PI_Q))) begin
			z1   = z0 + IW'(PI_Q);
			neg1 = 1'b1;
		end
	end

	assign xs = x_q >>> cmd.cidx;
	assign ys = y_q >>> cmd.cidx;

	always_comb begin
		ec = neg_q ? -x_q : x_q;
		es = neg_q ? -y_q : y_q;
		f  = IW'(ang_q) - es - IW'(m_q);
		fp = (IW'(1) <<< FRAC_BITS) - ec;
		if (fp < IW'(1)) fp = IW'(1);
		af = (f < 0) ? 32'(-f) : 32'(f);
	end

	assign rem_n = {rem_q, a_sh_q[QW-1]};
	assign ge    = rem_n >= {1'b0, d_q};

	always_comb begin
		qs    = (quo_q > QW'(QCAP)) ? QCAP : quo_q[32:0];
		stp   = fneg_q ? -36'(qs) : 36'(qs);
		nxt   = 36'(ang_q) - stp;
		nxt_c = nxt[AW-1:0];
		if (nxt < 0) nxt_c = '0;
		else if (nxt > 36'(TWO_PI_Q)) nxt_c = TWO_PI_Q;
		dif   = (36'(nxt_c) > 36'(ang_q)) ? 36'(nxt_c) - 36'(ang_q)
			: 36'(ang_q) - 36'(nxt_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= m_min;
			e_q   <= eccentricity;
			ang_q <= (eccentricity > high_ecc_threshold) ? PI_Q : m_min;
		end
		if (cmd.mul) begin
			mag_q <= EW'((prod + (EW+GW)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		end
		if (cmd.cinit) begin
			x_q   <= IW'(mag_q);
			y_q   <= '0;
			z_q   <= z1;
			neg_q <= neg1;
		end
		if (cmd.cstep) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ATAN_TAB[cmd.cidx];
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ATAN_TAB[cmd.cidx];
			end
		end
		if (cmd.prep) begin
			a_sh_q <= {af, FRAC_BITS'(0)};
			d_q    <= fp[DW-1:0];
			fneg_q <= (f < 0);
			rem_q  <= '0;
			quo_q  <= '0;
		end
		if (cmd.dstep) begin
			rem_q  <= ge ? DW'(rem_n - {1'b0, d_q}) : rem_n[DW-1:0];
			quo_q  <= {quo_q[QW-2:0], ge};
			a_sh_q <= a_sh_q << 1;
		end
		if (cmd.upd) begin
			ang_q  <= nxt_c;
			conv_q <= dif < 36'(step_tolerance);
		end
	end

	assign ang  = ang_q;
	assign conv = conv_q;
endmodule
`default_nettype wire

@@ bench/tb_kepler_equation_solver.sv @@
// ---------------------------------------------------------------------------
// tb_kepler_equation_solver: self-checking bench for the Kepler solver
// Drives mean anomaly and eccentricity requests over valid/ready, rewrites
// tolerance, iteration limit and high-eccentricity threshold between phases,
// and checks every solution against a bit-exact Newton-Raphson and CORDIC
// predictor under random idling and a long output hold-off.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_kepler_equation_solver;
	timeunit 1ns;
	timeprecision 1ps;
	import kes_pkg::*;

	localparam longint RUN_LIMIT = 10000000;
	localparam longint unsigned PI_Q60_C = 64'd3622009729038561421;
	localparam longint TWO_PI_IO = 1686629713;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [AW-1:0]   angle;
		logic            hit_limit;
		logic [LIMW-1:0] steps;
	} solution_t;

	class kepler_scoreboard;
		longint atan_q [0:FRAC_BITS];
		longint gain, pi_q, two_pi_q, half_pi_q;
		logic [TOLW-1:0] tol_reg;
		logic [LIMW-1:0] lim_reg;
		logic [EW-1:0]   thr_reg;
		solution_t pending_q [$];
		int errors, solved, limit_hits;

		function new();
			longint v, x, y, xs, ys;
			int ex;
			pi_q = longint'((PI_Q60_C + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
			two_pi_q = longint'((PI_Q60_C + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS));
			half_pi_q = longint'((PI_Q60_C + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
			for (int i = 0; i <= FRAC_BITS; i++) begin
				v = 0;
				if (i == 0) v = longint'(PI_Q60_C);
				else
					for (int k = 0; k < 40; k++) begin
						ex = 62 - i * (2 * k + 1);
						if (ex < 0) break;
						if (k % 2) v = v - (longint'(1) << ex) / (2 * k + 1);
						else v = v + (longint'(1) << ex) / (2 * k + 1);
					end
				atan_q[i] = longint'((longint'(unsigned'(v)) + (64'd1 << (61 - FRAC_BITS)))
					>> (62 - FRAC_BITS));
			end
			x = longint'(1) << FRAC_BITS;
			y = 0;
			for (int i = 0; i <= FRAC_BITS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
				end else begin
					x = x - ys;
					y = y + xs;
				end
			end
			gain = longint'(quotient(64'd1 << FRAC_BITS, x, 64'd1 << (FRAC_BITS + 4)));
			tol_reg = 1;
			lim_reg = 32;
			thr_reg = 214748365;
		endfunction

		// floor(a * 2^FRAC_BITS / d), clipped at cap
		function longint unsigned quotient(longint unsigned a, longint unsigned d,
				longint unsigned cap);
			longint unsigned rem, q, b;
			rem = 0;
			q = 0;
			if (d == 0) d = 1;
			for (int p = 2 * FRAC_BITS + 3; p >= 0; p--) begin
				b = (p >= FRAC_BITS) ? ((a >> (p - FRAC_BITS)) & 1) : 0;
				rem = (rem << 1) | b;
				q = q << 1;
				if (rem >= d) begin
					rem = rem - d;
					q = q | 1;
				end
				if (q > cap) return cap;
			end
			return q;
		endfunction

		function void rotate(longint ang, longint mag, output longint c, output longint s);
			longint x, y, z, xs, ys;
			bit flip;
			x = mag;
			y = 0;
			z = ang;
			flip = 0;
			if (z > pi_q) z = z - two_pi_q;
			if (z > half_pi_q) begin
				z = z - pi_q;
				flip = 1;
			end else if (z < -half_pi_q) begin
				z = z + pi_q;
				flip = 1;
			end
			for (int i = 0; i <= FRAC_BITS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q[i];
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void write_reg(logic [1:0] idx, logic [EW-1:0] data);
			case (idx)
				REG_TOL: tol_reg = data[TOLW-1:0];
				REG_LIM: lim_reg = data[LIMW-1:0];
				REG_THR: thr_reg = data;
				default: ;
			endcase
		endfunction

		function void note_request(logic [AW-1:0] m_raw, logic [EW-1:0] e_raw);
			longint m, e, mag, ang, tol, ec, es, f, fp, step, nxt, diff;
			longint unsigned q;
			int lim, used;
			bit done;
			solution_t s;
			lim = int'(lim_reg);
			if (lim < 1) lim = 1;
			if (lim > MAX_STEPS) lim = MAX_STEPS;
			m = longint'(m_raw);
			if (m > two_pi_q) m = two_pi_q;
			e = longint'(e_raw);
			mag = (e * gain + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			tol = longint'(tol_reg);
			ang = (e_raw > thr_reg) ? pi_q : m;
			done = 0;
			used = 0;
			for (int n = 1; n <= lim; n++) begin
				rotate(ang, mag, ec, es);
				f = ang - es - m;
				fp = (longint'(1) << FRAC_BITS) - ec;
				if (fp < 1) fp = 1;
				q = quotient(f < 0 ? -f : f, fp, 64'd1 << (FRAC_BITS + 4));
				step = f < 0 ? -longint'(q) : longint'(q);
				nxt = ang - step;
				if (nxt < 0) nxt = 0;
				if (nxt > two_pi_q) nxt = two_pi_q;
				diff = nxt > ang ? nxt - ang : ang - nxt;
				ang = nxt;
				used = n;
				if (diff < tol) begin
					done = 1;
					break;
				end
			end
			if (ang > TWO_PI_IO) ang = TWO_PI_IO;
			s.angle = ang[AW-1:0];
			s.hit_limit = !done;
			s.steps = used[LIMW-1:0];
			pending_q = {pending_q, s};
		endfunction

		function void check_result(logic [AW-1:0] angle, logic st, logic [LIMW-1:0] steps);
			solution_t s;
			if (pending_q.size() == 0) begin
				$error("result with no request outstanding: E=%0d", angle);
				errors++;
				return;
			end
			s = pending_q.pop_front();
			solved++;
			if (st) limit_hits++;
			if (angle !== s.angle) begin
				$error("eccentric_anomaly expected %0d actual %0d", s.angle, angle);
				errors++;
			end
			if (st !== s.hit_limit) begin
				$error("status expected %0d actual %0d", s.hit_limit, st);
				errors++;
			end
			if (steps !== s.steps) begin
				$error("iterations_used expected %0d actual %0d", s.steps, steps);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready, status;
	logic [AW-1:0] mean_anomaly, eccentric_anomaly;
	logic [EW-1:0] eccentricity, cfg_data;
	logic [LIMW-1:0] iterations_used;
	logic [1:0] cfg_index;

	kepler_scoreboard sb = new();
	int send_idle_pct, recv_stall_pct, requests;
	bit hold_request;
	int hold_left;
	longint cycles;

	kepler_equation_solver dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_request(mean_anomaly, eccentricity);
		if (arst_n && out_valid && out_ready)
			sb.check_result(eccentric_anomaly, status, iterations_used);
		if (arst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = 3000;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb_kepler_equation_solver failed");
			$finish;
		end
	end

	task automatic send(logic [AW-1:0] m, logic [EW-1:0] e);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid <= 1;
		mean_anomaly <= m;
		eccentricity <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		requests++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (sb.pending_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [EW-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic set_phase(logic [EW-1:0] tol, logic [EW-1:0] lim, logic [EW-1:0] thr,
			int idle, int stall);
		drain();
		write_cfg(REG_TOL, tol);
		write_cfg(REG_LIM, lim);
		write_cfg(REG_THR, thr);
		send_idle_pct = idle;
		recv_stall_pct = stall;
	endtask

	task automatic random_burst(int count);
		logic [AW-1:0] m;
		logic [EW-1:0] e;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: m = AW'($urandom());
				1: m = AW'($urandom_range(8));
				2: m = AW'(TWO_PI_IO - longint'($urandom_range(8)));
				default: m = AW'($urandom_range(32'(TWO_PI_IO)));
			endcase
			case ($urandom_range(5))
				0: e = EW'(32'hFFFFFFF - $urandom_range(1 << 20));
				1: e = EW'($urandom_range(1 << 16));
				default: e = EW'($urandom());
			endcase
			send(m, e);
		end
	endtask

	initial begin
		in_valid = 0;
		mean_anomaly = 0;
		eccentricity = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		out_ready = 0;
		hold_request = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		requests = 0;
		cycles = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset settings: edges of both fields and the start-guess switch
		send(0, 0);
		send(31'h7FFFFFFF, 0);
		send(31'h7FFFFFFF, 28'hFFFFFFF);
		send(AW'(TWO_PI_IO), 28'hFFFFFFF);
		send(AW'(TWO_PI_IO + 1), 28'h8000000);
		send(0, 28'hFFFFFFF);
		send(1, 28'hFFFFFFF);
		send(843314857, 28'hFFFFFFF);
		send(843314857, 0);
		send(421657428, 214748365);
		send(421657428, 214748366);
		send(421657428, 214748364);
		send(31'h55555555, 28'hAAAAAAA);
		send(31'h2AAAAAAA, 28'h5555555);
		send(AW'(TWO_PI_IO - 1), 28'h0000001);
		send(100, 28'hFFFFFF0);

		set_phase(1, 32, 214748365, 0, 0);
		random_burst(120);
		set_phase(65535, 64, 0, 76, 0);
		random_burst(80);
		set_phase(100, 1, 28'hFFFFFFF, 0, 76);
		random_burst(80);
		set_phase(16, 10, EW'($urandom()), 20, 20);
		hold_request = 1;
		random_burst(100);
		set_phase(0, 5, 28'hFFFFFFF, 0, 0);
		random_burst(20);
		// out-of-range limits, a write to the spare index
		set_phase(28'hFFF0000, 0, 28'h8000000, 30, 30);
		write_cfg(REG_SPARE, 28'hFFFFFFF);
		random_burst(10);
		set_phase(0, 28'hFFFFFFF, 28'hFFFFFFF, 0, 0);
		random_burst(5);
		set_phase(3, 127, 214748365, 0, 0);
		random_burst(10);

		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d requests over eight register settings, %0d solutions checked",
			requests, sb.solved);
		$display("%0d solutions hit the iteration limit, %0d mismatches",
			sb.limit_hits, sb.errors + sb.pending_q.size());
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tb_kepler_equation_solver passed");
		else
			$display("tb_kepler_equation_solver failed");
		$finish;
	end
endmodule
`default_nettype wire
